[src/mrr_pkg.sv]
// mrr_pkg: shared types, codes and constants of the Modbus RTU register responder
// used by mrr_ctrl, mrr_datapath and modbus_rtu_register_responder
// no dependencies
`default_nettype none

package mrr_pkg;

	// default sizes of the tables and of a read request
	localparam int TABLE_DEPTH_DEF = 16;
	localparam int MAX_READ_DEF    = 29;

	// configuration port
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 8;

	// register reset values
	localparam logic [7:0] SLAVE_ADDRESS_RST = 8'd1;
	localparam logic       CRC_LOW_FIRST_RST = 1'b1;
	localparam logic [4:0] ENTRIES_RST       = 5'd0;

	// crc-16, reflected form
	localparam logic [15:0] CRC_INIT = 16'hFFFF;
	localparam logic [15:0] CRC_POLY = 16'hA001;

	// modbus function codes that get a reply
	localparam logic [7:0] FC_READ_HOLDING = 8'd3;
	localparam logic [7:0] FC_READ_INPUT   = 8'd4;
	localparam logic [7:0] FC_WRITE_SINGLE = 8'd6;

	// configuration register indexes
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_SLAVE_ADDRESS   = 2'd0,
		REG_CRC_LOW_FIRST   = 2'd1,
		REG_HOLDING_ENTRIES = 2'd2,
		REG_INPUT_ENTRIES   = 2'd3
	} reg_idx_t;

	// item kinds
	typedef enum logic [1:0] {
		OP_REQUEST   = 2'd0,
		OP_SET_ADDR  = 2'd1,
		OP_SET_VALUE = 2'd2
	} op_t;

	// source of the next reply byte
	typedef enum logic [3:0] {
		SRC_SLAVE      = 4'd0,
		SRC_CODE       = 4'd1,
		SRC_BYTE_COUNT = 4'd2,
		SRC_START_HI   = 4'd3,
		SRC_START_LO   = 4'd4,
		SRC_VALUE_HI   = 4'd5,
		SRC_VALUE_LO   = 4'd6,
		SRC_WORD_HI    = 4'd7,
		SRC_WORD_LO    = 4'd8,
		SRC_CRC_FIRST  = 4'd9,
		SRC_CRC_SECOND = 4'd10
	} byte_src_t;

	// controller to datapath
	typedef struct packed {
		logic      capture;    // latch the incoming item
		logic      setup_wr;   // write a table entry from a set-up item
		logic      start;      // load request working registers, clear crc
		logic      scan_clr;   // restart the table scan
		logic      scan_inc;   // step to the next table entry
		logic      word_load;  // take the matched entry's value
		logic      word_clr;   // no match: word reads as zero
		logic      wr_hit;     // store the write value into the matched entry
		logic      addr_inc;   // step to the next register address
		logic      emit;       // load a reply byte when the output is free
		byte_src_t src;
		logic      last;
	} mrr_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic is_setup;
		logic is_req;
		logic is_read;
		logic is_write;
		logic cnt_ok;
		logic words_zero;
		logic scan_end;
		logic match;
		logic out_ready;
	} mrr_sts_t;

	// one byte through the crc-16 register, one bit per step
	function automatic logic [15:0] crc_byte(input logic [15:0] crc_in, input logic [7:0] data);
		logic [15:0] c;
		c = crc_in ^ {8'h00, data};
		for (int b = 0; b < 8; b++) begin
			c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
		end
		return c;
	endfunction

endpackage

`default_nettype wire

[src/mrr_ctrl.sv]
// mrr_ctrl: sequencer of the register responder
// depends on mrr_pkg for the command and status structs
`default_nettype none

module mrr_ctrl (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             req_valid,
	output logic                  req_stall,
	input  wire mrr_pkg::mrr_sts_t sts,
	output mrr_pkg::mrr_cmd_t     cmd
);

	typedef enum logic [4:0] {
		S_IDLE,
		S_DECODE,
		S_WSCAN_RD,
		S_WSCAN_CMP,
		S_HDR_SLAVE,
		S_HDR_CODE,
		S_HDR_BCNT,
		S_NEXT_WORD,
		S_SCAN_RD,
		S_SCAN_CMP,
		S_DATA_HI,
		S_DATA_LO,
		S_ECHO_SHI,
		S_ECHO_SLO,
		S_ECHO_VHI,
		S_ECHO_VLO,
		S_CRC_FIRST,
		S_CRC_SECOND
	} state_t;

	state_t state_q;
	state_t state_nxt;

	assign req_stall = (state_q != S_IDLE);

	// next state and commands
	always_comb begin
		state_nxt = state_q;
		cmd       = '0;
		cmd.src   = mrr_pkg::SRC_SLAVE;
		unique case (state_q)
			S_IDLE: begin
				cmd.capture = req_valid;
				if (req_valid) state_nxt = S_DECODE;
			end
			S_DECODE: begin
				priority if (sts.is_setup) begin
					cmd.setup_wr = 1'b1;
					state_nxt    = S_IDLE;
				end else if (sts.is_req && sts.is_read && sts.cnt_ok) begin
					cmd.start = 1'b1;
					state_nxt = S_HDR_SLAVE;
				end else if (sts.is_req && sts.is_write) begin
					cmd.start = 1'b1;
					state_nxt = S_WSCAN_RD;
				end else begin
					state_nxt = S_IDLE;
				end
			end
			// single write: find the first holding entry with this address
			S_WSCAN_RD: begin
				state_nxt = sts.scan_end ? S_HDR_SLAVE : S_WSCAN_CMP;
			end
			S_WSCAN_CMP: begin
				if (sts.match) begin
					cmd.wr_hit = 1'b1;
					state_nxt  = S_HDR_SLAVE;
				end else begin
					cmd.scan_inc = 1'b1;
					state_nxt    = S_WSCAN_RD;
				end
			end
			S_HDR_SLAVE: begin
				cmd.emit = 1'b1;
				cmd.src  = mrr_pkg::SRC_SLAVE;
				if (sts.out_ready) state_nxt = S_HDR_CODE;
			end
			S_HDR_CODE: begin
				cmd.emit = 1'b1;
				cmd.src  = mrr_pkg::SRC_CODE;
				if (sts.out_ready) state_nxt = sts.is_read ? S_HDR_BCNT : S_ECHO_SHI;
			end
			S_HDR_BCNT: begin
				cmd.emit = 1'b1;
				cmd.src  = mrr_pkg::SRC_BYTE_COUNT;
				if (sts.out_ready) state_nxt = S_NEXT_WORD;
			end
			S_NEXT_WORD: begin
				if (sts.words_zero) begin
					state_nxt = S_CRC_FIRST;
				end else begin
					cmd.scan_clr = 1'b1;
					state_nxt    = S_SCAN_RD;
				end
			end
			// read: read then compare one table entry at a time until a match or the end
			S_SCAN_RD: begin
				if (sts.scan_end) begin
					cmd.word_clr = 1'b1;
					state_nxt    = S_DATA_HI;
				end else begin
					state_nxt = S_SCAN_CMP;
				end
			end
			S_SCAN_CMP: begin
				if (sts.match) begin
					cmd.word_load = 1'b1;
					state_nxt     = S_DATA_HI;
				end else begin
					cmd.scan_inc = 1'b1;
					state_nxt    = S_SCAN_RD;
				end
			end
			S_DATA_HI: begin
				cmd.emit = 1'b1;
				cmd.src  = mrr_pkg::SRC_WORD_HI;
				if (sts.out_ready) state_nxt = S_DATA_LO;
			end
			S_DATA_LO: begin
				cmd.emit = 1'b1;
				cmd.src  = mrr_pkg::SRC_WORD_LO;
				if (sts.out_ready) begin
					cmd.addr_inc = 1'b1;
					state_nxt    = S_NEXT_WORD;
				end
			end
			S_ECHO_SHI: begin
				cmd.emit = 1'b1;
				cmd.src  = mrr_pkg::SRC_START_HI;
				if (sts.out_ready) state_nxt = S_ECHO_SLO;
			end
			S_ECHO_SLO: begin
				cmd.emit = 1'b1;
				cmd.src  = mrr_pkg::SRC_START_LO;
				if (sts.out_ready) state_nxt = S_ECHO_VHI;
			end
			S_ECHO_VHI: begin
				cmd.emit = 1'b1;
				cmd.src  = mrr_pkg::SRC_VALUE_HI;
				if (sts.out_ready) state_nxt = S_ECHO_VLO;
			end
			S_ECHO_VLO: begin
				cmd.emit = 1'b1;
				cmd.src  = mrr_pkg::SRC_VALUE_LO;
				if (sts.out_ready) state_nxt = S_CRC_FIRST;
			end
			S_CRC_FIRST: begin
				cmd.emit = 1'b1;
				cmd.src  = mrr_pkg::SRC_CRC_FIRST;
				if (sts.out_ready) state_nxt = S_CRC_SECOND;
			end
			S_CRC_SECOND: begin
				cmd.emit = 1'b1;
				cmd.src  = mrr_pkg::SRC_CRC_SECOND;
				cmd.last = 1'b1;
				if (sts.out_ready) state_nxt = S_IDLE;
			end
			default: state_nxt = S_IDLE;
		endcase
	end

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

endmodule

`default_nettype wire

[src/mrr_datapath.sv]
// mrr_datapath: configuration, register tables, table scan, crc-16 and reply output register
// depends on mrr_pkg; driven by mrr_ctrl through mrr_cmd_t
`default_nettype none

module mrr_datapath #(
	parameter int TABLE_DEPTH = mrr_pkg::TABLE_DEPTH_DEF,
	parameter int MAX_READ    = mrr_pkg::MAX_READ_DEF
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           cfg_we,
	input  wire logic [mrr_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [mrr_pkg::CFG_DATA_W-1:0] cfg_data,
	input  wire logic [1:0]                     opcode,
	input  wire logic                           table_select,
	input  wire logic [3:0]                     entry_index,
	input  wire logic [15:0]                    entry_word,
	input  wire logic [7:0]                     function_code,
	input  wire logic [15:0]                    start_address,
	input  wire logic [15:0]                    count_or_value,
	input  wire mrr_pkg::mrr_cmd_t              cmd,
	output mrr_pkg::mrr_sts_t                   sts,
	input  wire logic                           rsp_stall,
	output logic                                rsp_valid,
	output logic [7:0]                          reply_byte,
	output logic                                last_byte
);

	localparam int IW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
	localparam int SW = $clog2(TABLE_DEPTH + 1);
	localparam int WW = $clog2(MAX_READ + 1);

	// configuration registers
	logic [7:0] slave_addr_q;
	logic       crc_lo_first_q;
	logic [4:0] hold_n_q;
	logic [4:0] inp_n_q;

	// captured item
	logic [1:0]  opcode_q;
	logic        tsel_q;
	logic [3:0]  idx_q;
	logic [15:0] eword_q;
	logic [7:0]  code_q;
	logic [15:0] start_q;
	logic [15:0] cv_q;

	// request working registers
	logic [15:0]   addr_q;
	logic [WW-1:0] words_q;
	logic          tab_q;
	logic [SW-1:0] scan_q;
	logic [15:0]   word_q;
	logic [15:0]   crc_q;

	// tables
	logic [15:0] haddr_mem [TABLE_DEPTH];
	logic [15:0] hval_mem  [TABLE_DEPTH];
	logic [15:0] iaddr_mem [TABLE_DEPTH];
	logic [15:0] ival_mem  [TABLE_DEPTH];
	logic [TABLE_DEPTH-1:0] hval_vld_q;
	logic [TABLE_DEPTH-1:0] ival_vld_q;
	logic [15:0] rd_addr_s1;
	logic [15:0] rd_val_s1;
	logic        rd_vld_s1;

	// output register
	logic       out_valid_q;
	logic [7:0] out_byte_q;
	logic       out_last_q;

	logic          idx_ok;
	logic [IW-1:0] widx;
	logic [IW-1:0] sidx;
	logic [4:0]    n_sel;
	logic [SW-1:0] n_used;
	logic          hv_we;
	logic [IW-1:0] hv_wa;
	logic [15:0]   hv_wd;
	logic          iv_we;
	logic          ha_we;
	logic          ia_we;
	logic          out_ready;
	logic          out_load;
	logic [7:0]    byte_mux;
	logic          is_crc_src;

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slave_addr_q   <= mrr_pkg::SLAVE_ADDRESS_RST;
			crc_lo_first_q <= mrr_pkg::CRC_LOW_FIRST_RST;
			hold_n_q       <= mrr_pkg::ENTRIES_RST;
			inp_n_q        <= mrr_pkg::ENTRIES_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				mrr_pkg::REG_SLAVE_ADDRESS:   slave_addr_q   <= cfg_data[7:0];
				mrr_pkg::REG_CRC_LOW_FIRST:   crc_lo_first_q <= cfg_data[0];
				mrr_pkg::REG_HOLDING_ENTRIES: hold_n_q       <= cfg_data[4:0];
				mrr_pkg::REG_INPUT_ENTRIES:   inp_n_q        <= cfg_data[4:0];
				default: ;
			endcase
		end
	end

	// item capture
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			opcode_q <= opcode;
			tsel_q   <= table_select;
			idx_q    <= entry_index;
			eword_q  <= entry_word;
			code_q   <= function_code;
			start_q  <= start_address;
			cv_q     <= count_or_value;
		end
	end

	// entries in use, clipped to the table depth
	assign n_sel = tab_q ? inp_n_q : hold_n_q;
	always_comb begin
		if (32'(n_sel) > TABLE_DEPTH) begin
			n_used = SW'(TABLE_DEPTH);
		end else begin
			n_used = SW'(n_sel);
		end
	end

	assign idx_ok = (32'(idx_q) < TABLE_DEPTH);
	assign widx   = IW'(idx_q);
	assign sidx   = scan_q[IW-1:0];

	// table write enables; holding values take set-up writes and write hits
	always_comb begin
		ha_we = cmd.setup_wr && idx_ok && (opcode_q == mrr_pkg::OP_SET_ADDR) && !tsel_q;
		ia_we = cmd.setup_wr && idx_ok && (opcode_q == mrr_pkg::OP_SET_ADDR) && tsel_q;
		iv_we = cmd.setup_wr && idx_ok && (opcode_q == mrr_pkg::OP_SET_VALUE) && tsel_q;
		hv_we = (cmd.setup_wr && idx_ok && (opcode_q == mrr_pkg::OP_SET_VALUE) && !tsel_q)
			|| cmd.wr_hit;
		hv_wa = cmd.wr_hit ? sidx : widx;
		hv_wd = cmd.wr_hit ? cv_q : eword_q;
	end

	// table memories with registered read at the scan index
	always_ff @(posedge clk) begin
		if (ha_we) haddr_mem[widx] <= eword_q;
		if (ia_we) iaddr_mem[widx] <= eword_q;
		if (iv_we) ival_mem[widx] <= eword_q;
		if (hv_we) hval_mem[hv_wa] <= hv_wd;
		rd_addr_s1 <= tab_q ? iaddr_mem[sidx] : haddr_mem[sidx];
		rd_val_s1  <= tab_q ? ival_mem[sidx] : hval_mem[sidx];
		rd_vld_s1  <= tab_q ? ival_vld_q[sidx] : hval_vld_q[sidx];
	end

	// value valid bits: an unwritten value reads as zero
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hval_vld_q <= '0;
			ival_vld_q <= '0;
		end else begin
			if (hv_we) hval_vld_q[hv_wa] <= 1'b1;
			if (iv_we) ival_vld_q[widx] <= 1'b1;
		end
	end

	// reply byte selection
	always_comb begin
		unique case (cmd.src)
			mrr_pkg::SRC_SLAVE:      byte_mux = slave_addr_q;
			mrr_pkg::SRC_CODE:       byte_mux = code_q;
			mrr_pkg::SRC_BYTE_COUNT: byte_mux = {cv_q[6:0], 1'b0};
			mrr_pkg::SRC_START_HI:   byte_mux = start_q[15:8];
			mrr_pkg::SRC_START_LO:   byte_mux = start_q[7:0];
			mrr_pkg::SRC_VALUE_HI:   byte_mux = cv_q[15:8];
			mrr_pkg::SRC_VALUE_LO:   byte_mux = cv_q[7:0];
			mrr_pkg::SRC_WORD_HI:    byte_mux = word_q[15:8];
			mrr_pkg::SRC_WORD_LO:    byte_mux = word_q[7:0];
			mrr_pkg::SRC_CRC_FIRST:  byte_mux = crc_lo_first_q ? crc_q[7:0] : crc_q[15:8];
			mrr_pkg::SRC_CRC_SECOND: byte_mux = crc_lo_first_q ? crc_q[15:8] : crc_q[7:0];
			default:                 byte_mux = 8'h00;
		endcase
	end

	assign is_crc_src = (cmd.src == mrr_pkg::SRC_CRC_FIRST)
		|| (cmd.src == mrr_pkg::SRC_CRC_SECOND);
	assign out_ready = !out_valid_q || !rsp_stall;
	assign out_load  = cmd.emit && out_ready;

	// request working registers and running crc
	always_ff @(posedge clk) begin
		if (cmd.start) begin
			addr_q  <= start_q;
			words_q <= WW'(cv_q);
			tab_q   <= (code_q == mrr_pkg::FC_READ_INPUT);
		end else if (cmd.addr_inc) begin
			addr_q  <= addr_q + 16'd1;
			words_q <= words_q - WW'(1);
		end
		priority if (cmd.start || cmd.scan_clr) begin
			scan_q <= '0;
		end else if (cmd.scan_inc) begin
			scan_q <= scan_q + SW'(1);
		end else begin
			scan_q <= scan_q;
		end
		if (cmd.word_load) begin
			word_q <= rd_vld_s1 ? rd_val_s1 : 16'h0000;
		end else if (cmd.word_clr) begin
			word_q <= 16'h0000;
		end
		if (cmd.start) begin
			crc_q <= mrr_pkg::CRC_INIT;
		end else if (out_load && !is_crc_src) begin
			crc_q <= mrr_pkg::crc_byte(crc_q, byte_mux);
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (!rsp_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_byte_q <= byte_mux;
			out_last_q <= cmd.last;
		end
	end

	assign rsp_valid  = out_valid_q;
	assign reply_byte = out_byte_q;
	assign last_byte  = out_last_q;

	// status for the sequencer
	always_comb begin
		sts            = '0;
		sts.is_setup   = (opcode_q == mrr_pkg::OP_SET_ADDR) || (opcode_q == mrr_pkg::OP_SET_VALUE);
		sts.is_req     = (opcode_q == mrr_pkg::OP_REQUEST);
		sts.is_read    = (code_q == mrr_pkg::FC_READ_HOLDING) || (code_q == mrr_pkg::FC_READ_INPUT);
		sts.is_write   = (code_q == mrr_pkg::FC_WRITE_SINGLE);
		sts.cnt_ok     = (32'(cv_q) <= MAX_READ);
		sts.words_zero = (words_q == '0);
		sts.scan_end   = (scan_q == n_used);
		sts.match      = (rd_addr_s1 == addr_q);
		sts.out_ready  = out_ready;
	end

endmodule

`default_nettype wire

[src/modbus_rtu_register_responder.sv]
// modbus_rtu_register_responder: top level of the Modbus RTU slave register responder
// depends on mrr_pkg, mrr_ctrl and mrr_datapath
`default_nettype none

// Takes one item at a time on the req channel: set-up items write an address or a value
// into the holding or input table and give no reply; requests with code 3 or 4 read
// registers, code 6 writes one holding register, and each of these replies with one byte
// per rsp item, ending with the CRC-16 (last_byte marks the final byte). Other codes and
// reads of more than MAX_READ registers are dropped silently. An item is held for its
// whole reply: a set-up item is captured, then decoded; a request is captured, decoded,
// then emits its reply bytes in order, and every register word also starts a
// search of the table, one entry at a time through the registered table read port,
// stopping at the first match; a single write searches the holding table the same
// way before its echo. Stalls on rsp hold the reply in place.
// The tables need no clearing after reset.
module modbus_rtu_register_responder #(
	parameter int TABLE_DEPTH = mrr_pkg::TABLE_DEPTH_DEF,
	parameter int MAX_READ    = mrr_pkg::MAX_READ_DEF
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           cfg_we,
	input  wire logic [mrr_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [mrr_pkg::CFG_DATA_W-1:0] cfg_data,
	input  wire logic                           req_valid,
	output logic                                req_stall,
	input  wire logic [1:0]                     opcode,
	input  wire logic                           table_select,
	input  wire logic [3:0]                     entry_index,
	input  wire logic [15:0]                    entry_word,
	input  wire logic [7:0]                     function_code,
	input  wire logic [15:0]                    start_address,
	input  wire logic [15:0]                    count_or_value,
	output logic                                rsp_valid,
	input  wire logic                           rsp_stall,
	output logic [7:0]                          reply_byte,
	output logic                                last_byte
);

	mrr_pkg::mrr_cmd_t cmd;
	mrr_pkg::mrr_sts_t sts;

	// sequencer
	mrr_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.sts       (sts),
		.cmd       (cmd)
	);

	// tables, crc and output register
	mrr_datapath #(
		.TABLE_DEPTH (TABLE_DEPTH),
		.MAX_READ    (MAX_READ)
	) u_datapath (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_we         (cfg_we),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data),
		.opcode         (opcode),
		.table_select   (table_select),
		.entry_index    (entry_index),
		.entry_word     (entry_word),
		.function_code  (function_code),
		.start_address  (start_address),
		.count_or_value (count_or_value),
		.cmd            (cmd),
		.sts            (sts),
		.rsp_stall      (rsp_stall),
		.rsp_valid      (rsp_valid),
		.reply_byte     (reply_byte),
		.last_byte      (last_byte)
	);

	// an accepted item holds off the next one while it is decoded
	a_accept_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && !req_stall |=> req_stall)
		else $error("item accepted while the previous one was still being decoded");

	// capture, table write, request start and byte emit never overlap
	a_cmd_exclusive: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({cmd.capture, cmd.setup_wr, cmd.start, cmd.emit}))
		else $error("controller issued overlapping commands");

	// a stalled reply byte stays offered and unchanged
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_stall |=> rsp_valid && $stable(reply_byte) && $stable(last_byte))
		else $error("reply byte changed while stalled");

endmodule

`default_nettype wire

[verif/tb_modbus_rtu_register_responder.sv]
// tb_modbus_rtu_register_responder: self-checking testbench of the Modbus RTU register responder
// predicts every reply byte from its own copy of the tables and registers
// depends on mrr_pkg and modbus_rtu_register_responder
`default_nettype none

module tb_modbus_rtu_register_responder;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int DEPTH       = mrr_pkg::TABLE_DEPTH_DEF;
	localparam int READ_LIMIT  = mrr_pkg::MAX_READ_DEF;
	localparam int FRAME_MAX   = 3 + 2 * READ_LIMIT + 2;
	localparam int SETTLE      = 40;
	localparam int CYCLE_LIMIT = 1000000;
	localparam int PRINT_CAP   = 40;

	localparam logic [1:0]  OP_UNUSED         = 2'd3;
	localparam logic [7:0]  FC_WRITE_MULTIPLE = 8'h10;
	localparam logic [15:0] ADDR_BASE         = 16'h4000;

	// one input item
	typedef struct {
		logic [1:0]  opcode;
		logic        table_select;
		logic [3:0]  entry_index;
		logic [15:0] entry_word;
		logic [7:0]  function_code;
		logic [15:0] start_address;
		logic [15:0] count_or_value;
	} req_item_t;

	// one expected reply byte
	typedef struct {
		logic [7:0] data;
		logic       last;
	} reply_exp_t;

	logic        clk = 1'b0;
	logic        arst_n;
	logic        cfg_we;
	logic [mrr_pkg::CFG_IDX_W-1:0]  cfg_index;
	logic [mrr_pkg::CFG_DATA_W-1:0] cfg_data;
	logic        req_valid;
	logic        req_stall;
	logic [1:0]  opcode;
	logic        table_select;
	logic [3:0]  entry_index;
	logic [15:0] entry_word;
	logic [7:0]  function_code;
	logic [15:0] start_address;
	logic [15:0] count_or_value;
	logic        rsp_valid;
	logic        rsp_stall = 1'b0;
	logic [7:0]  reply_byte;
	logic        last_byte;

	// predicted state of the block
	logic [15:0] tbl_hold_addr [0:DEPTH-1];
	logic [15:0] tbl_hold_val  [0:DEPTH-1];
	logic [15:0] tbl_in_addr   [0:DEPTH-1];
	logic [15:0] tbl_in_val    [0:DEPTH-1];
	logic [7:0]  cfg_slave;
	logic        cfg_crc_low;
	logic [4:0]  cfg_hold_cnt;
	logic [4:0]  cfg_in_cnt;

	reply_exp_t reply_queue [$];
	reply_exp_t exp_now;

	int mismatch_count = 0;
	int checked_count  = 0;
	int sent_count     = 0;
	int cycle_count    = 0;
	int send_idle_pct  = 0;
	int rsp_stall_pct  = 0;
	int hold_left      = 0;

	modbus_rtu_register_responder u_dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_we         (cfg_we),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data),
		.req_valid      (req_valid),
		.req_stall      (req_stall),
		.opcode         (opcode),
		.table_select   (table_select),
		.entry_index    (entry_index),
		.entry_word     (entry_word),
		.function_code  (function_code),
		.start_address  (start_address),
		.count_or_value (count_or_value),
		.rsp_valid      (rsp_valid),
		.rsp_stall      (rsp_stall),
		.reply_byte     (reply_byte),
		.last_byte      (last_byte)
	);

	// clock
	always #10 clk = ~clk;

	// run limit
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d reply bytes still pending",
				cycle_count, reply_queue.size());
			$display("modbus_rtu_register_responder verification failed");
			$finish;
		end
	end

	task automatic report_mismatch(input string what, input logic [15:0] want,
			input logic [15:0] got);
		// keep the log short on a badly broken block
		if (mismatch_count < PRINT_CAP)
			$display("mismatch at cycle %0d: %s expected %h got %h", cycle_count, what, want, got);
		mismatch_count++;
	endtask

	// receiver: long hold-off first, otherwise random stalls
	always @(negedge clk) begin
		if (hold_left > 0) begin
			rsp_stall = 1'b1;
			hold_left--;
		end else begin
			rsp_stall = ($urandom_range(99) < rsp_stall_pct);
		end
	end

	// compare each accepted reply byte with the oldest prediction
	always @(posedge clk) begin
		if (arst_n && rsp_valid && !rsp_stall) begin
			if (reply_queue.size() == 0) begin
				report_mismatch("reply byte with none pending", 16'h0, {7'h0, last_byte, reply_byte});
			end else begin
				exp_now = reply_queue.pop_front();
				if (reply_byte !== exp_now.data)
					report_mismatch("reply_byte", {8'h00, exp_now.data}, {8'h00, reply_byte});
				if (last_byte !== exp_now.last)
					report_mismatch("last_byte", {15'h0, exp_now.last}, {15'h0, last_byte});
				checked_count++;
			end
		end
	end

	// crc-16 over one byte, reflected
	function automatic logic [15:0] crc_step(input logic [15:0] crc, input logic [7:0] data);
		logic [15:0] acc;
		acc = crc ^ {8'h00, data};
		for (int b = 0; b < 8; b++) begin
			if (acc[0])
				acc = (acc >> 1) ^ mrr_pkg::CRC_POLY;
			else
				acc = acc >> 1;
		end
		return acc;
	endfunction

	// first entry in use that holds the address, or -1
	function automatic int find_entry(input logic use_input, input logic [15:0] addr);
		int n;
		n = int'(use_input ? cfg_in_cnt : cfg_hold_cnt);
		if (n > DEPTH)
			n = DEPTH;
		for (int j = 0; j < n; j++) begin
			if (use_input ? (tbl_in_addr[j] == addr) : (tbl_hold_addr[j] == addr))
				return j;
		end
		return -1;
	endfunction

	// update the predicted tables and queue the reply bytes of one item
	task automatic predict_reply(input req_item_t it);
		logic [7:0]  frame [0:FRAME_MAX-1];
		logic [15:0] addr;
		logic [15:0] word;
		logic [15:0] crc;
		logic        use_input;
		int          len;
		int          hit;
		reply_exp_t  rb;
		len = 0;
		case (it.opcode)
			mrr_pkg::OP_SET_ADDR: begin
				if (it.table_select)
					tbl_in_addr[it.entry_index] = it.entry_word;
				else
					tbl_hold_addr[it.entry_index] = it.entry_word;
			end
			mrr_pkg::OP_SET_VALUE: begin
				if (it.table_select)
					tbl_in_val[it.entry_index] = it.entry_word;
				else
					tbl_hold_val[it.entry_index] = it.entry_word;
			end
			mrr_pkg::OP_REQUEST: begin
				if ((it.function_code == mrr_pkg::FC_READ_HOLDING
						|| it.function_code == mrr_pkg::FC_READ_INPUT)
						&& it.count_or_value <= READ_LIMIT) begin
					use_input = (it.function_code == mrr_pkg::FC_READ_INPUT);
					frame[0] = cfg_slave;
					frame[1] = it.function_code;
					frame[2] = {it.count_or_value[6:0], 1'b0};
					len = 3;
					addr = it.start_address;
					for (int i = 0; i < it.count_or_value; i++) begin
						hit = find_entry(use_input, addr);
						if (hit < 0)
							word = 16'h0000;
						else
							word = use_input ? tbl_in_val[hit] : tbl_hold_val[hit];
						frame[len]     = word[15:8];
						frame[len + 1] = word[7:0];
						len += 2;
						addr = addr + 16'd1;
					end
				end else if (it.function_code == mrr_pkg::FC_WRITE_SINGLE) begin
					hit = find_entry(1'b0, it.start_address);
					if (hit >= 0)
						tbl_hold_val[hit] = it.count_or_value;
					frame[0] = cfg_slave;
					frame[1] = mrr_pkg::FC_WRITE_SINGLE;
					frame[2] = it.start_address[15:8];
					frame[3] = it.start_address[7:0];
					frame[4] = it.count_or_value[15:8];
					frame[5] = it.count_or_value[7:0];
					len = 6;
				end
			end
			default: ;
		endcase
		if (len > 0) begin
			crc = mrr_pkg::CRC_INIT;
			for (int k = 0; k < len; k++)
				crc = crc_step(crc, frame[k]);
			frame[len]     = cfg_crc_low ? crc[7:0] : crc[15:8];
			frame[len + 1] = cfg_crc_low ? crc[15:8] : crc[7:0];
			len += 2;
			for (int k = 0; k < len; k++) begin
				rb.data = frame[k];
				rb.last = (k == len - 1);
				reply_queue.push_back(rb);
			end
		end
	endtask

	// offer one item, hold it until accepted; starts and ends at a falling edge
	task automatic send_item(input req_item_t it);
		while ($urandom_range(99) < send_idle_pct) begin
			req_valid = 1'b0;
			@(negedge clk);
		end
		opcode         = it.opcode;
		table_select   = it.table_select;
		entry_index    = it.entry_index;
		entry_word     = it.entry_word;
		function_code  = it.function_code;
		start_address  = it.start_address;
		count_or_value = it.count_or_value;
		req_valid      = 1'b1;
		do
			@(posedge clk);
		while (req_stall);
		predict_reply(it);
		if (it.opcode != OP_UNUSED)
			sent_count++;
		@(negedge clk);
	endtask

	// wait for every pending reply byte, then let the block settle
	task automatic wait_idle();
		req_valid = 1'b0;
		while (reply_queue.size() != 0)
			@(negedge clk);
		repeat (SETTLE) @(negedge clk);
	endtask

	task automatic write_reg(input mrr_pkg::reg_idx_t idx, input logic [7:0] data);
		cfg_we    = 1'b1;
		cfg_index = idx;
		cfg_data  = data;
		case (idx)
			mrr_pkg::REG_SLAVE_ADDRESS:   cfg_slave    = data;
			mrr_pkg::REG_CRC_LOW_FIRST:   cfg_crc_low  = data[0];
			mrr_pkg::REG_HOLDING_ENTRIES: cfg_hold_cnt = data[4:0];
			mrr_pkg::REG_INPUT_ENTRIES:   cfg_in_cnt   = data[4:0];
			default: ;
		endcase
		@(negedge clk);
		cfg_we = 1'b0;
	endtask

	task automatic apply_config(input logic [7:0] slave, input logic crc_low,
			input logic [4:0] hold_cnt, input logic [4:0] in_cnt);
		wait_idle();
		write_reg(mrr_pkg::REG_SLAVE_ADDRESS, slave);
		write_reg(mrr_pkg::REG_CRC_LOW_FIRST, {7'h0, crc_low});
		write_reg(mrr_pkg::REG_HOLDING_ENTRIES, {3'h0, hold_cnt});
		write_reg(mrr_pkg::REG_INPUT_ENTRIES, {3'h0, in_cnt});
	endtask

	// item with random content in every field the opcode does not use
	function automatic req_item_t random_fields();
		req_item_t it;
		it.opcode         = mrr_pkg::OP_REQUEST;
		it.table_select   = 1'($urandom_range(1));
		it.entry_index    = 4'($urandom_range(15));
		it.entry_word     = 16'($urandom);
		it.function_code  = 8'($urandom);
		it.start_address  = 16'($urandom);
		it.count_or_value = 16'($urandom);
		return it;
	endfunction

	function automatic req_item_t make_request(input logic [7:0] code,
			input logic [15:0] start, input logic [15:0] cv);
		req_item_t it;
		it = random_fields();
		it.function_code  = code;
		it.start_address  = start;
		it.count_or_value = cv;
		return it;
	endfunction

	function automatic req_item_t make_setup(input logic [1:0] op, input logic sel,
			input logic [3:0] idx, input logic [15:0] word);
		req_item_t it;
		it = random_fields();
		it.opcode       = op;
		it.table_select = sel;
		it.entry_index  = idx;
		it.entry_word   = word;
		return it;
	endfunction

	// addresses near the table window or the 16-bit wrap, sometimes anywhere
	function automatic logic [15:0] pick_addr();
		int r;
		r = $urandom_range(99);
		if (r < 70)
			return ADDR_BASE + 16'($urandom_range(47));
		else if (r < 90)
			return 16'hFFF0 + 16'($urandom_range(31));
		return 16'($urandom);
	endfunction

	// mostly well-formed set-up items and requests, some noise
	function automatic req_item_t random_item();
		req_item_t it;
		int r;
		int k;
		it = random_fields();
		r = $urandom_range(99);
		if (r < 25) begin
			it.opcode = $urandom_range(1) ? mrr_pkg::OP_SET_ADDR : mrr_pkg::OP_SET_VALUE;
			if (it.opcode == mrr_pkg::OP_SET_ADDR)
				it.entry_word = pick_addr();
		end else if (r < 85) begin
			k = $urandom_range(9);
			it.function_code = (k < 4) ? mrr_pkg::FC_READ_HOLDING
				: (k < 8) ? mrr_pkg::FC_READ_INPUT : mrr_pkg::FC_WRITE_SINGLE;
			it.start_address = pick_addr();
			if (it.function_code != mrr_pkg::FC_WRITE_SINGLE)
				it.count_or_value = ($urandom_range(3) == 0)
					? 16'($urandom_range(READ_LIMIT, 7)) : 16'($urandom_range(6));
		end else if (r < 95) begin
			// oversized reads or random codes
			if ($urandom_range(1)) begin
				it.function_code  = $urandom_range(1) ? mrr_pkg::FC_READ_HOLDING
					: mrr_pkg::FC_READ_INPUT;
				it.count_or_value = 16'($urandom_range(65535, READ_LIMIT + 1));
			end
		end else begin
			it.opcode = OP_UNUSED;
		end
		return it;
	endfunction

	// load every address of both tables: window, a duplicate, and the wrap ends
	task automatic test_table_load();
		logic [15:0] a;
		for (int j = 0; j < DEPTH; j++) begin
			a = (j == 5) ? ADDR_BASE + 16'd3 : (j == 14) ? 16'hFFFF : (j == 15) ? 16'h0000
				: ADDR_BASE + 16'(j);
			send_item(make_setup(mrr_pkg::OP_SET_ADDR, 1'b0, 4'(j), a));
			a = (j == 14) ? 16'hFFFF : (j == 15) ? 16'h0000 : ADDR_BASE + 16'(2 * j);
			send_item(make_setup(mrr_pkg::OP_SET_ADDR, 1'b1, 4'(j), a));
		end
		// values of the lower half; the rest stay zero until random traffic writes them
		for (int j = 0; j < DEPTH / 2; j++) begin
			a = (j == 0) ? 16'hFFFF : (j == 1) ? 16'h0000 : 16'($urandom);
			send_item(make_setup(mrr_pkg::OP_SET_VALUE, 1'b0, 4'(j), a));
			send_item(make_setup(mrr_pkg::OP_SET_VALUE, 1'b1, 4'(j), 16'($urandom)));
		end
		wait_idle();
	endtask

	// field extremes, every code and the special cases
	task automatic test_directed();
		req_item_t it;
		// empty tables read as zero, zero count still gets a crc
		send_item(make_request(mrr_pkg::FC_READ_HOLDING, ADDR_BASE, 16'd1));
		send_item(make_request(mrr_pkg::FC_READ_INPUT, ADDR_BASE, 16'd0));
		apply_config(8'hFF, 1'b0, 5'd16, 5'd16);
		send_item(make_request(mrr_pkg::FC_READ_HOLDING, ADDR_BASE, 16'd8));
		// address wrap at 16 bits
		send_item(make_request(mrr_pkg::FC_READ_HOLDING, 16'hFFFE, 16'd4));
		send_item(make_request(mrr_pkg::FC_READ_INPUT, ADDR_BASE, 16'(READ_LIMIT)));
		// oversized reads are dropped
		send_item(make_request(mrr_pkg::FC_READ_INPUT, ADDR_BASE, 16'(READ_LIMIT + 1)));
		send_item(make_request(mrr_pkg::FC_READ_HOLDING, 16'h0000, 16'hFFFF));
		// write with a match, read it back, write without a match, then one to the wrap-end entry
		send_item(make_request(mrr_pkg::FC_WRITE_SINGLE, ADDR_BASE + 16'd3, 16'hA5C3));
		send_item(make_request(mrr_pkg::FC_READ_HOLDING, ADDR_BASE + 16'd3, 16'd1));
		send_item(make_request(mrr_pkg::FC_WRITE_SINGLE, 16'h1234, 16'hFFFF));
		send_item(make_request(mrr_pkg::FC_WRITE_SINGLE, 16'h0000, 16'h0000));
		// codes with no reply
		send_item(make_request(FC_WRITE_MULTIPLE, ADDR_BASE, 16'd2));
		send_item(make_request(8'h00, ADDR_BASE, 16'd1));
		send_item(make_request(8'hFF, ADDR_BASE, 16'd1));
		send_item(make_request(8'h05, ADDR_BASE, 16'd1));
		it = random_fields();
		it.opcode = OP_UNUSED;
		send_item(it);
		// entry counts above the depth act as the depth
		apply_config(8'h00, 1'b1, 5'd17, 5'd31);
		send_item(make_request(mrr_pkg::FC_READ_HOLDING, 16'hFFFF, 16'd2));
		send_item(make_request(mrr_pkg::FC_READ_INPUT, ADDR_BASE + 16'd28, 16'd3));
		// a single holding entry in use, input table empty
		apply_config(8'h5A, 1'b0, 5'd1, 5'd0);
		send_item(make_request(mrr_pkg::FC_READ_HOLDING, ADDR_BASE, 16'd3));
		send_item(make_request(mrr_pkg::FC_READ_INPUT, ADDR_BASE, 16'd2));
		wait_idle();
	endtask

	// one random phase under a given idle mix
	task automatic test_random_traffic(input int idle_pct, input int stall_pct, input int n);
		req_item_t it;
		int done;
		apply_config(8'($urandom), 1'($urandom_range(1)),
			($urandom_range(3) == 0) ? 5'd16 : 5'($urandom_range(16)),
			($urandom_range(3) == 0) ? 5'd16 : 5'($urandom_range(16)));
		send_idle_pct = idle_pct;
		rsp_stall_pct = stall_pct;
		done = 0;
		while (done < n) begin
			it = random_item();
			send_item(it);
			if (it.opcode != OP_UNUSED)
				done++;
		end
		wait_idle();
	endtask

	// receiver holds off while long reads keep coming, so the input stalls
	task automatic test_output_holdoff();
		apply_config(8'h11, 1'b1, 5'd16, 5'd16);
		send_idle_pct = 0;
		rsp_stall_pct = 10;
		hold_left = 300;
		for (int i = 0; i < 6; i++)
			send_item(make_request($urandom_range(1) ? mrr_pkg::FC_READ_HOLDING
				: mrr_pkg::FC_READ_INPUT, pick_addr(), 16'($urandom_range(READ_LIMIT, 10))));
		wait_idle();
	endtask

	// sender pauses until every reply has drained, then goes on
	task automatic test_sender_pause();
		send_idle_pct = 15;
		rsp_stall_pct = 30;
		for (int i = 0; i < 4; i++)
			send_item(random_item());
		req_valid = 1'b0;
		while (reply_queue.size() != 0)
			@(negedge clk);
		for (int i = 0; i < 4; i++)
			send_item(random_item());
		wait_idle();
	endtask

	initial begin
		arst_n         = 1'b0;
		cfg_we         = 1'b0;
		cfg_index      = mrr_pkg::REG_SLAVE_ADDRESS;
		cfg_data       = 8'h00;
		req_valid      = 1'b0;
		opcode         = mrr_pkg::OP_REQUEST;
		table_select   = 1'b0;
		entry_index    = 4'h0;
		entry_word     = 16'h0000;
		function_code  = 8'h00;
		start_address  = 16'h0000;
		count_or_value = 16'h0000;
		// predicted reset state
		for (int j = 0; j < DEPTH; j++) begin
			tbl_hold_addr[j] = 16'h0000;
			tbl_hold_val[j]  = 16'h0000;
			tbl_in_addr[j]   = 16'h0000;
			tbl_in_val[j]    = 16'h0000;
		end
		cfg_slave    = mrr_pkg::SLAVE_ADDRESS_RST;
		cfg_crc_low  = mrr_pkg::CRC_LOW_FIRST_RST;
		cfg_hold_cnt = mrr_pkg::ENTRIES_RST;
		cfg_in_cnt   = mrr_pkg::ENTRIES_RST;

		repeat (10) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		test_table_load();
		test_directed();
		test_random_traffic(0, 0, 10);
		test_random_traffic(48, 0, 10);
		test_random_traffic(0, 48, 10);
		test_random_traffic(15, 15, 10);
		test_output_holdoff();
		test_sender_pause();

		if (reply_queue.size() != 0)
			report_mismatch("reply bytes never sent", 16'(reply_queue.size()), 16'h0);
		$display("run: %0d items sent, %0d reply bytes checked, %0d mismatches", sent_count,
			checked_count, mismatch_count);
		$display("run: table loads, directed codes and extremes, four idle mixes, hold-off, pause");
		if (mismatch_count == 0) begin
			$display("modbus_rtu_register_responder verification clean");
		end else begin
			$display("modbus_rtu_register_responder verification failed");
		end
		$finish;
	end

endmodule

`default_nettype wire

[sim.f]
src/mrr_pkg.sv
src/mrr_ctrl.sv
src/mrr_datapath.sv
src/modbus_rtu_register_responder.sv
verif/tb_modbus_rtu_register_responder.sv
